### rtl/core/max_window_sum_finder_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the max window sum finder core
// Concurrent assertion wrappers; define ASSERT_OFF to compile them out.
// ----------------------------------------------------------------------------
`ifndef MAX_WINDOW_SUM_FINDER_CORE_MACROS_SVH
`define MAX_WINDOW_SUM_FINDER_CORE_MACROS_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define MWSF_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define MWSF_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define MWSF_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define MWSF_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

### rtl/core/mwsf_pkg.sv
// ----------------------------------------------------------------------------
// mwsf_pkg
// Shared sizes, register codes and the per-sample control struct.
// ----------------------------------------------------------------------------
package mwsf_pkg;

	localparam int MAX_SIDE     = 64;
	localparam int MAX_WINDOW   = 8;
	localparam int SAMPLE_WIDTH = 16;

	localparam int SIDE_W     = $clog2(MAX_SIDE);
	localparam int SIZE_W     = $clog2(MAX_SIDE + 1);
	localparam int WIN_W      = $clog2(MAX_WINDOW + 1);
	localparam int SLOT_W     = $clog2(MAX_WINDOW);
	localparam int CMP_W      = ((SIZE_W > WIN_W) ? SIZE_W : WIN_W) + 1;
	localparam int LINE_DEPTH = MAX_WINDOW * MAX_SIDE;
	localparam int LINE_AW    = $clog2(LINE_DEPTH);
	localparam int COL_W      = SAMPLE_WIDTH + $clog2(MAX_WINDOW);
	localparam int SUM_W      = SAMPLE_WIDTH + 2 * $clog2(MAX_WINDOW);

	// configuration port
	localparam int MATRIX_REG_W = 7;
	localparam int WINDOW_REG_W = 4;
	localparam int CFG_DATA_W   = 7;
	localparam int CFG_IDX_W    = 1;

	localparam logic [CFG_IDX_W-1:0] REG_MATRIX_SIZE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE = 1'b1;

	localparam int MATRIX_RESET = 64;
	localparam int WINDOW_RESET = 2;
	localparam int MIN_SIZE     = 2;

	// per-sample control, travels down the pipeline with the sample
	typedef struct packed {
		logic [SIDE_W-1:0] col;
		logic [SLOT_W-1:0] row_slot;
		logic [SLOT_W-1:0] col_slot;
		logic              first_row;
		logic              first_col;
		logic              row_full;
		logic              col_full;
		logic              in_window;
		logic              last;
		logic [SIDE_W-1:0] top;
		logic [SIDE_W-1:0] left;
	} ctl_t;

endpackage

### rtl/core/mwsf_in_if.sv
// ----------------------------------------------------------------------------
// mwsf_in_if
// Sample channel: valid/ready handshake carrying one matrix element.
// ----------------------------------------------------------------------------
interface mwsf_in_if;
	logic                                     valid;
	logic                                     ready;
	logic signed [mwsf_pkg::SAMPLE_WIDTH-1:0] sample_value;

	modport source (output valid, output sample_value, input ready);
	modport sink   (input valid, input sample_value, output ready);
endinterface

### rtl/core/mwsf_out_if.sv
// ----------------------------------------------------------------------------
// mwsf_out_if
// Result channel: valid/ready handshake carrying the best window.
// ----------------------------------------------------------------------------
interface mwsf_out_if;
	logic                              valid;
	logic                              ready;
	logic signed [mwsf_pkg::SUM_W-1:0] best_sum;
	logic [mwsf_pkg::SIDE_W-1:0]       best_top_row;
	logic [mwsf_pkg::SIDE_W-1:0]       best_left_col;
	logic                              found;

	modport source (output valid, output best_sum, output best_top_row,
		output best_left_col, output found, input ready);
	modport sink   (input valid, input best_sum, input best_top_row,
		input best_left_col, input found, output ready);
endinterface

### rtl/core/mwsf_ram.sv
// ----------------------------------------------------------------------------
// mwsf_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module mwsf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_q <= mem[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

### rtl/core/mwsf_seq.sv
// ----------------------------------------------------------------------------
// mwsf_seq
// Config registers, raster position counters and per-sample control flags.
// ----------------------------------------------------------------------------
`include "max_window_sum_finder_core_macros.svh"

module mwsf_seq (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                wr_en,
	input  logic [mwsf_pkg::CFG_IDX_W-1:0]      wr_index,
	input  logic [mwsf_pkg::CFG_DATA_W-1:0]     wr_data,
	input  logic                                in_valid,
	input  logic                                out_busy,
	output logic                                in_ready,
	output logic                                accept,
	output logic                                restart,
	output mwsf_pkg::ctl_t                      ctl
);

	logic [mwsf_pkg::SIZE_W-1:0] n_q;
	logic [mwsf_pkg::WIN_W-1:0]  m_q;
	logic [mwsf_pkg::SIDE_W-1:0] r_q;
	logic [mwsf_pkg::SIDE_W-1:0] c_q;
	logic [mwsf_pkg::SLOT_W-1:0] rslot_q;
	logic [mwsf_pkg::SLOT_W-1:0] cslot_q;

	logic [mwsf_pkg::MATRIX_REG_W-1:0] n_raw;
	logic [mwsf_pkg::WINDOW_REG_W-1:0] m_raw;
	logic [mwsf_pkg::SIZE_W-1:0]       n_wr;
	logic [mwsf_pkg::WIN_W-1:0]        m_wr;

	logic [mwsf_pkg::CMP_W-1:0] r_c, c_c, rp1, cp1, m_c, n_c;
	logic                       last_col;
	logic                       rslot_wrap, cslot_wrap;

	// clamp written sizes into the supported range
	always_comb begin
		n_raw = wr_data[mwsf_pkg::MATRIX_REG_W-1:0];
		m_raw = wr_data[mwsf_pkg::WINDOW_REG_W-1:0];
		if (int'(n_raw) < mwsf_pkg::MIN_SIZE) begin
			n_wr = mwsf_pkg::SIZE_W'(mwsf_pkg::MIN_SIZE);
		end else if (int'(n_raw) > mwsf_pkg::MAX_SIDE) begin
			n_wr = mwsf_pkg::SIZE_W'(mwsf_pkg::MAX_SIDE);
		end else begin
			n_wr = mwsf_pkg::SIZE_W'(n_raw);
		end
		if (int'(m_raw) < mwsf_pkg::MIN_SIZE) begin
			m_wr = mwsf_pkg::WIN_W'(mwsf_pkg::MIN_SIZE);
		end else if (int'(m_raw) > mwsf_pkg::MAX_WINDOW) begin
			m_wr = mwsf_pkg::WIN_W'(mwsf_pkg::MAX_WINDOW);
		end else begin
			m_wr = mwsf_pkg::WIN_W'(m_raw);
		end
	end

	always_comb begin
		r_c = mwsf_pkg::CMP_W'(r_q);
		c_c = mwsf_pkg::CMP_W'(c_q);
		m_c = mwsf_pkg::CMP_W'(m_q);
		n_c = mwsf_pkg::CMP_W'(n_q);
		rp1 = r_c + mwsf_pkg::CMP_W'(1);
		cp1 = c_c + mwsf_pkg::CMP_W'(1);

		last_col   = (cp1 == n_c);
		rslot_wrap = (mwsf_pkg::CMP_W'(rslot_q) + mwsf_pkg::CMP_W'(1) == m_c);
		cslot_wrap = (mwsf_pkg::CMP_W'(cslot_q) + mwsf_pkg::CMP_W'(1) == m_c);

		ctl.col       = c_q;
		ctl.row_slot  = rslot_q;
		ctl.col_slot  = cslot_q;
		ctl.first_row = (r_q == '0);
		ctl.first_col = (c_q == '0);
		ctl.row_full  = (r_c >= m_c);
		ctl.col_full  = (c_c >= m_c);
		ctl.in_window = (rp1 >= m_c) && (cp1 >= m_c);
		ctl.last      = last_col && (rp1 == n_c);
		ctl.top       = mwsf_pkg::SIDE_W'(rp1 - m_c);
		ctl.left      = mwsf_pkg::SIDE_W'(cp1 - m_c);
	end

	// hold the frame's last sample while the previous result still waits
	assign in_ready = !(ctl.last && out_busy);
	assign accept   = in_valid && in_ready;
	assign restart  = wr_en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q     <= mwsf_pkg::SIZE_W'(mwsf_pkg::MATRIX_RESET);
			m_q     <= mwsf_pkg::WIN_W'(mwsf_pkg::WINDOW_RESET);
			r_q     <= '0;
			c_q     <= '0;
			rslot_q <= '0;
			cslot_q <= '0;
		end else if (wr_en) begin
			case (wr_index)
				mwsf_pkg::REG_MATRIX_SIZE: n_q <= n_wr;
				mwsf_pkg::REG_WINDOW_SIZE: m_q <= m_wr;
				default: ;
			endcase
			r_q     <= '0;
			c_q     <= '0;
			rslot_q <= '0;
			cslot_q <= '0;
		end else if (accept) begin
			if (last_col) begin
				c_q     <= '0;
				cslot_q <= '0;
				if (ctl.last) begin
					r_q     <= '0;
					rslot_q <= '0;
				end else begin
					r_q     <= r_q + mwsf_pkg::SIDE_W'(1);
					rslot_q <= rslot_wrap ? '0 : rslot_q + mwsf_pkg::SLOT_W'(1);
				end
			end else begin
				c_q     <= c_q + mwsf_pkg::SIDE_W'(1);
				cslot_q <= cslot_wrap ? '0 : cslot_q + mwsf_pkg::SLOT_W'(1);
			end
		end
	end

	`MWSF_ASSERT_IMP(a_pos_in_frame, clk, arst_n, 1'b1, (r_c < n_c) && (c_c < n_c), "position outside matrix")

endmodule

### rtl/core/mwsf_col.sv
// ----------------------------------------------------------------------------
// mwsf_col
// Line store and column-sum memories; read at accept, update in the next cycle.
// ----------------------------------------------------------------------------
`include "max_window_sum_finder_core_macros.svh"

module mwsf_col (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     accept,
	input  mwsf_pkg::ctl_t                           ctl,
	input  logic signed [mwsf_pkg::SAMPLE_WIDTH-1:0] sample,
	output logic                                     cs_valid,
	output mwsf_pkg::ctl_t                           cs_ctl,
	output logic signed [mwsf_pkg::COL_W-1:0]        cs
);

	logic                                     valid_s1;
	mwsf_pkg::ctl_t                           ctl_s1;
	logic signed [mwsf_pkg::SAMPLE_WIDTH-1:0] x_s1;

	logic [mwsf_pkg::LINE_AW-1:0]      line_raddr, line_waddr;
	logic [mwsf_pkg::SAMPLE_WIDTH-1:0] line_rd;
	logic [mwsf_pkg::COL_W-1:0]        col_rd;

	logic signed [mwsf_pkg::COL_W-1:0] prev, leaving, x_ext;

	assign line_raddr = mwsf_pkg::LINE_AW'(int'(ctl.row_slot) * mwsf_pkg::MAX_SIDE
		+ int'(ctl.col));
	assign line_waddr = mwsf_pkg::LINE_AW'(int'(ctl_s1.row_slot) * mwsf_pkg::MAX_SIDE
		+ int'(ctl_s1.col));

	mwsf_ram #(
		.WIDTH (mwsf_pkg::SAMPLE_WIDTH),
		.DEPTH (mwsf_pkg::LINE_DEPTH)
	) u_line (
		.clk     (clk),
		.wr_en   (valid_s1),
		.wr_addr (line_waddr),
		.wr_data (x_s1),
		.rd_addr (line_raddr),
		.rd_data (line_rd)
	);

	mwsf_ram #(
		.WIDTH (mwsf_pkg::COL_W),
		.DEPTH (mwsf_pkg::MAX_SIDE)
	) u_colsum (
		.clk     (clk),
		.wr_en   (valid_s1),
		.wr_addr (ctl_s1.col),
		.wr_data (cs),
		.rd_addr (ctl.col),
		.rd_data (col_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ctl_s1 <= ctl;
			x_s1   <= sample;
		end
	end

	// first row rebuilds the column from zero; past m rows the oldest leaves
	always_comb begin
		x_ext   = {{(mwsf_pkg::COL_W - mwsf_pkg::SAMPLE_WIDTH){x_s1[mwsf_pkg::SAMPLE_WIDTH-1]}},
			x_s1};
		prev    = ctl_s1.first_row ? '0 : col_rd;
		leaving = ctl_s1.row_full
			? {{(mwsf_pkg::COL_W - mwsf_pkg::SAMPLE_WIDTH){line_rd[mwsf_pkg::SAMPLE_WIDTH-1]}},
				line_rd}
			: '0;
		cs      = prev + x_ext - leaving;
	end

	assign cs_valid = valid_s1;
	assign cs_ctl   = ctl_s1;

	// consecutive samples always sit in different columns, so no forwarding
	`MWSF_ASSERT_IMP(a_no_col_collision, clk, arst_n, valid_s1 && accept, ctl.col != ctl_s1.col, "column read hits pending write")

endmodule

### rtl/core/mwsf_win.sv
// ----------------------------------------------------------------------------
// mwsf_win
// Sliding window total over recent column sums, best tracking, result register.
// ----------------------------------------------------------------------------
`include "max_window_sum_finder_core_macros.svh"

module mwsf_win (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               restart,
	input  logic                               cs_valid,
	input  mwsf_pkg::ctl_t                     cs_ctl,
	input  logic signed [mwsf_pkg::COL_W-1:0]  cs,
	input  logic                               out_ready,
	output logic                               out_valid,
	output logic signed [mwsf_pkg::SUM_W-1:0]  best_sum,
	output logic [mwsf_pkg::SIDE_W-1:0]        best_top_row,
	output logic [mwsf_pkg::SIDE_W-1:0]        best_left_col,
	output logic                               found
);

	// stage 2: window total
	logic                              valid_s2;
	mwsf_pkg::ctl_t                    ctl_s2;
	logic signed [mwsf_pkg::COL_W-1:0] cs_s2;
	logic signed [mwsf_pkg::COL_W-1:0] recent_q [mwsf_pkg::MAX_WINDOW];
	logic signed [mwsf_pkg::SUM_W-1:0] wt_q;
	logic signed [mwsf_pkg::SUM_W-1:0] base, dropped, added, tot;

	// stage 3: best tracking
	logic                              valid_s3;
	logic signed [mwsf_pkg::SUM_W-1:0] tot_s3;
	logic                              win_s3;
	logic                              last_s3;
	logic [mwsf_pkg::SIDE_W-1:0]       top_s3, left_s3;

	logic                              have_q;
	logic signed [mwsf_pkg::SUM_W-1:0] best_q;
	logic [mwsf_pkg::SIDE_W-1:0]       top_q, left_q;
	logic                              take, have_nx;
	logic signed [mwsf_pkg::SUM_W-1:0] best_nx;
	logic [mwsf_pkg::SIDE_W-1:0]       top_nx, left_nx;

	// result register
	logic                              out_valid_q;
	logic signed [mwsf_pkg::SUM_W-1:0] sum_q;
	logic [mwsf_pkg::SIDE_W-1:0]       row_q, col_q;
	logic                              found_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s2 <= cs_valid;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (cs_valid) begin
			ctl_s2 <= cs_ctl;
			cs_s2  <= cs;
		end
	end

	// drop the column sum that left the window, add the new one
	always_comb begin
		base    = ctl_s2.first_col ? '0 : wt_q;
		dropped = ctl_s2.col_full
			? {{(mwsf_pkg::SUM_W - mwsf_pkg::COL_W){recent_q[ctl_s2.col_slot][mwsf_pkg::COL_W-1]}},
				recent_q[ctl_s2.col_slot]}
			: '0;
		added   = {{(mwsf_pkg::SUM_W - mwsf_pkg::COL_W){cs_s2[mwsf_pkg::COL_W-1]}}, cs_s2};
		tot     = base - dropped + added;
	end

	always_ff @(posedge clk) begin
		if (valid_s2) begin
			wt_q                      <= tot;
			recent_q[ctl_s2.col_slot] <= cs_s2;
			tot_s3                    <= tot;
			win_s3                    <= ctl_s2.in_window;
			last_s3                   <= ctl_s2.last;
			top_s3                    <= ctl_s2.top;
			left_s3                   <= ctl_s2.left;
		end
	end

	// strict greater keeps the first window on ties
	always_comb begin
		take    = win_s3 && (!have_q || (tot_s3 > best_q));
		have_nx = have_q || take;
		best_nx = take ? tot_s3  : best_q;
		top_nx  = take ? top_s3  : top_q;
		left_nx = take ? left_s3 : left_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_q <= 1'b0;
			best_q <= '0;
			top_q  <= '0;
			left_q <= '0;
		end else if (restart || (valid_s3 && last_s3)) begin
			have_q <= 1'b0;
			best_q <= '0;
			top_q  <= '0;
			left_q <= '0;
		end else if (valid_s3) begin
			have_q <= have_nx;
			best_q <= best_nx;
			top_q  <= top_nx;
			left_q <= left_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (valid_s3 && last_s3) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s3 && last_s3) begin
			sum_q   <= have_nx ? best_nx : '0;
			row_q   <= have_nx ? top_nx  : '0;
			col_q   <= have_nx ? left_nx : '0;
			found_q <= have_nx;
		end
	end

	assign out_valid     = out_valid_q;
	assign best_sum      = sum_q;
	assign best_top_row  = row_q;
	assign best_left_col = col_q;
	assign found         = found_q;

	`MWSF_ASSERT_IMP(a_result_not_lost, clk, arst_n, valid_s3 && last_s3, !out_valid_q || out_ready, "result overwrites pending result")
	`MWSF_ASSERT_NXT(a_best_cleared, clk, arst_n, valid_s3 && last_s3, !have_q, "best tracking not cleared after frame")
	`MWSF_ASSERT_IMP(a_empty_result_zero, clk, arst_n, out_valid_q && !found_q, (sum_q == '0) && (row_q == '0) && (col_q == '0), "empty result not zero")

endmodule

### rtl/core/max_window_sum_finder_core.sv
// ----------------------------------------------------------------------------
// max_window_sum_finder_core
// Largest m-by-m window sum over an n-by-n matrix streamed in raster order.
// ----------------------------------------------------------------------------
// One sample transaction is taken every clock. The only stall is on the
// last sample of a frame, held while the previous frame's result has not
// been taken yet. The rate is set by the column-sum memory: each sample
// reads its column entry in the accept cycle and writes the updated sum
// back in the next cycle, and neighboring samples always touch different
// columns, so the read-modify-write never overlaps itself. Storage is a
// 512x16 line store (last m rows) and a 64-entry column-sum memory; neither
// needs a clearing pass since the first row of every frame rebuilds the
// column sums. Writing either size register restarts the frame; write only
// while idle.
// ----------------------------------------------------------------------------
//
// Pipeline:
//   accept : counters give row/column, slots and window flags; both memories
//            are read (line store at row slot/column, column sum at column)
//   s1     : column sum = old sum + new sample - sample leaving the window;
//            both memories written back
//   s2     : window total = previous total - sum leaving + new column sum,
//            kept over a ring of the last m column sums
//   s3     : compare against best (strict greater, first window wins ties)
//   out    : result register, one transaction per frame
//
// Sizes are clamped on write: n to 2..64, m to 2..8. With m > n no window
// fits and the result carries found = 0 and zero fields.

module max_window_sum_finder_core (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            wr_en,
	input  logic [mwsf_pkg::CFG_IDX_W-1:0]  wr_index,
	input  logic [mwsf_pkg::CFG_DATA_W-1:0] wr_data,
	mwsf_in_if.sink                         samples,
	mwsf_out_if.source                      results
);

	logic                              accept;
	logic                              restart;
	logic                              out_busy;
	mwsf_pkg::ctl_t                    ctl;
	logic                              cs_valid;
	mwsf_pkg::ctl_t                    cs_ctl;
	logic signed [mwsf_pkg::COL_W-1:0] cs;

	// a result still sitting in the output register blocks the next frame end
	assign out_busy = results.valid && !results.ready;

	// position counters, size registers, per-sample flags
	mwsf_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.in_valid (samples.valid),
		.out_busy (out_busy),
		.in_ready (samples.ready),
		.accept   (accept),
		.restart  (restart),
		.ctl      (ctl)
	);

	// line store and column sums, read-modify-write
	mwsf_col u_col (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.ctl      (ctl),
		.sample   (samples.sample_value),
		.cs_valid (cs_valid),
		.cs_ctl   (cs_ctl),
		.cs       (cs)
	);

	// window total, best tracking, result register
	mwsf_win u_win (
		.clk           (clk),
		.arst_n        (arst_n),
		.restart       (restart),
		.cs_valid      (cs_valid),
		.cs_ctl        (cs_ctl),
		.cs            (cs),
		.out_ready     (results.ready),
		.out_valid     (results.valid),
		.best_sum      (results.best_sum),
		.best_top_row  (results.best_top_row),
		.best_left_col (results.best_left_col),
		.found         (results.found)
	);

endmodule

### tb/mwsf_best_window_monitor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mwsf_best_window_monitor
// Follows the size registers and the sample stream, keeps its own line store,
// column sums and window totals, and checks every result transaction
// against the best window it expects for the frame.
// ----------------------------------------------------------------------------
module mwsf_best_window_monitor (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            wr_en,
	input  logic [mwsf_pkg::CFG_IDX_W-1:0]  wr_index,
	input  logic [mwsf_pkg::CFG_DATA_W-1:0] wr_data,
	mwsf_in_if                              samples,
	mwsf_out_if                             results,
	output int                              mismatch_count,
	output int                              open_results
);

	typedef struct packed {
		logic signed [mwsf_pkg::SUM_W-1:0] sum;
		logic [mwsf_pkg::SIDE_W-1:0]       top_row;
		logic [mwsf_pkg::SIDE_W-1:0]       left_col;
		logic                              found;
	} best_window_t;

	logic [mwsf_pkg::MATRIX_REG_W-1:0] side_cfg;
	logic [mwsf_pkg::WINDOW_REG_W-1:0] window_cfg;

	int line_mem [mwsf_pkg::LINE_DEPTH];
	int col_sum [mwsf_pkg::MAX_SIDE];
	int recent_cols [mwsf_pkg::MAX_WINDOW];
	int strip_total;
	int row_at;
	int col_at;
	int lead_sum;
	int lead_row;
	int lead_col;
	bit lead_valid;

	best_window_t best_windows_q [$];
	int fails = 0;
	int queued = 0;

	assign mismatch_count = fails;
	assign open_results   = queued;

	function automatic int side_used();
		if (side_cfg < mwsf_pkg::MIN_SIZE) return mwsf_pkg::MIN_SIZE;
		if (side_cfg > mwsf_pkg::MAX_SIDE) return mwsf_pkg::MAX_SIDE;
		return int'(side_cfg);
	endfunction

	function automatic int window_used();
		if (window_cfg < mwsf_pkg::MIN_SIZE) return mwsf_pkg::MIN_SIZE;
		if (window_cfg > mwsf_pkg::MAX_WINDOW) return mwsf_pkg::MAX_WINDOW;
		return int'(window_cfg);
	endfunction

	task automatic clear_frame();
		row_at      = 0;
		col_at      = 0;
		strip_total = 0;
		lead_sum    = 0;
		lead_row    = 0;
		lead_col    = 0;
		lead_valid  = 1'b0;
	endtask

	task automatic report(input string msg);
		$display("%0t ns  mismatch: %s", $time, msg);
		fails++;
	endtask

	// one sample: update column sum, window total and best window
	task automatic track_sample(input logic signed [mwsf_pkg::SAMPLE_WIDTH-1:0] s);
		int n, m, r, c, x, idx, leaving, cs, tot;
		best_window_t res;
		n = side_used();
		m = window_used();
		r = row_at;
		c = col_at;
		x = s;
		if (r >= n || c >= n) begin
			r = 0;
			c = 0;
		end
		idx     = (r % m) * mwsf_pkg::MAX_SIDE + c;
		leaving = (r >= m) ? line_mem[idx] : 0;
		cs      = ((r == 0) ? 0 : col_sum[c]) + x - leaving;
		col_sum[c]    = cs;
		line_mem[idx] = x;

		tot = (c == 0) ? 0 : strip_total;
		if (c >= m)
			tot -= recent_cols[c % m];
		recent_cols[c % m] = cs;
		tot += cs;
		strip_total = tot;

		// strict greater: earliest window in raster order keeps a tie
		if (r + 1 >= m && c + 1 >= m) begin
			if (!lead_valid || tot > lead_sum) begin
				lead_sum   = tot;
				lead_row   = r + 1 - m;
				lead_col   = c + 1 - m;
				lead_valid = 1'b1;
			end
		end

		if (c + 1 == n) begin
			if (r + 1 == n) begin
				res = '0;
				if (lead_valid) begin
					res.sum      = mwsf_pkg::SUM_W'(lead_sum);
					res.top_row  = mwsf_pkg::SIDE_W'(lead_row);
					res.left_col = mwsf_pkg::SIDE_W'(lead_col);
					res.found    = 1'b1;
				end
				best_windows_q = {best_windows_q, res};
				clear_frame();
			end else begin
				row_at = r + 1;
				col_at = 0;
			end
		end else begin
			row_at = r;
			col_at = c + 1;
		end
	endtask

	task automatic check_result();
		best_window_t want;
		if (best_windows_q.size() == 0) begin
			report($sformatf("result with none expected (sum %0d row %0d col %0d found %0b)",
				results.best_sum, results.best_top_row, results.best_left_col,
				results.found));
		end else begin
			want = best_windows_q.pop_front();
			if (results.found !== want.found)
				report($sformatf("found %b, expected %b", results.found, want.found));
			if (results.best_sum !== want.sum)
				report($sformatf("best_sum %0d, expected %0d", results.best_sum, want.sum));
			if (results.best_top_row !== want.top_row)
				report($sformatf("best_top_row %0d, expected %0d",
					results.best_top_row, want.top_row));
			if (results.best_left_col !== want.left_col)
				report($sformatf("best_left_col %0d, expected %0d",
					results.best_left_col, want.left_col));
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_cfg   = mwsf_pkg::MATRIX_REG_W'(mwsf_pkg::MATRIX_RESET);
			window_cfg = mwsf_pkg::WINDOW_REG_W'(mwsf_pkg::WINDOW_RESET);
			foreach (line_mem[i]) line_mem[i] = 0;
			foreach (col_sum[i]) col_sum[i] = 0;
			foreach (recent_cols[i]) recent_cols[i] = 0;
			clear_frame();
			best_windows_q.delete();
			queued <= 0;
		end else begin
			// results first: a result never belongs to a sample of this edge
			if (results.valid && results.ready)
				check_result();
			if (wr_en) begin
				if (wr_index == mwsf_pkg::REG_MATRIX_SIZE)
					side_cfg = wr_data[mwsf_pkg::MATRIX_REG_W-1:0];
				else
					window_cfg = wr_data[mwsf_pkg::WINDOW_REG_W-1:0];
				clear_frame();
			end
			if (samples.valid && samples.ready)
				track_sample(samples.sample_value);
			queued <= best_windows_q.size();
		end
	end

endmodule

### tb/max_window_sum_finder_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// max_window_sum_finder_core_tb
// Streams square matrices through the core under many size settings and
// checks each frame's best window via the monitor; random stalls both sides.
// ----------------------------------------------------------------------------
module max_window_sum_finder_core_tb;

	localparam int RX_HOLD        = 300;   // long receiver hold-off, cycles
	localparam int WATCHDOG_LIMIT = 4000;  // cycles with no transaction at all
	localparam int DRAIN_PAD      = 8;     // margin for the core pipeline to empty
	localparam int RANDOM_ITEMS   = 900;
	localparam int MIN_FRAMES     = 8;
	localparam int IDLE_PCT       = 31;

	localparam logic signed [mwsf_pkg::SAMPLE_WIDTH-1:0] SAMPLE_MAX =
		{1'b0, {(mwsf_pkg::SAMPLE_WIDTH-1){1'b1}}};
	localparam logic signed [mwsf_pkg::SAMPLE_WIDTH-1:0] SAMPLE_MIN =
		{1'b1, {(mwsf_pkg::SAMPLE_WIDTH-1){1'b0}}};

	// content styles for one frame
	typedef enum int {FILL_FULL, FILL_SMALL, FILL_FLAT, FILL_EDGE, FILL_LOW} fill_t;

	logic                            clk = 1'b0;
	logic                            arst_n;
	logic                            wr_en;
	logic [mwsf_pkg::CFG_IDX_W-1:0]  wr_index;
	logic [mwsf_pkg::CFG_DATA_W-1:0] wr_data;

	int mismatch_count;
	int open_results;

	// stimulus bookkeeping
	int items_sent    = 0;
	int frames_sent   = 0;
	int side_now      = mwsf_pkg::MATRIX_RESET;   // effective n, sets the frame length
	bit calm          = 1'b0;           // no idling on either side while set
	int hold_requests = 0;              // bumped to ask the receiver for a hold-off
	int hold_taken    = 0;
	int hold_left     = 0;
	int idle_cycles   = 0;

	mwsf_in_if  samples_if ();
	mwsf_out_if results_if ();

	max_window_sum_finder_core u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.samples  (samples_if),
		.results  (results_if)
	);

	mwsf_best_window_monitor u_monitor (
		.clk            (clk),
		.arst_n         (arst_n),
		.wr_en          (wr_en),
		.wr_index       (wr_index),
		.wr_data        (wr_data),
		.samples        (samples_if),
		.results        (results_if),
		.mismatch_count (mismatch_count),
		.open_results   (open_results)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------------
	// Result side: random back-pressure, plus one long hold-off on request.
	// During the hold the core keeps taking samples until the last sample of
	// the next frame, which it must stall while the earlier result waits.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			results_if.ready <= 1'b0;
		end else if (hold_requests != hold_taken) begin
			hold_taken <= hold_requests;
			hold_left <= RX_HOLD;
			results_if.ready <= 1'b0;
		end else begin
			results_if.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
		end
	end

	// ------------------------------------------------------------------------
	// Watchdog: any transaction on either channel restarts the count.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if ((samples_if.valid && samples_if.ready) ||
			(results_if.valid && results_if.ready) || !arst_n) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("no transaction for %0d cycles", idle_cycles);
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Sample driver
	// ------------------------------------------------------------------------

	// Offer one sample and hold it until the transaction happens. Valid stays
	// high on return so back-to-back samples are offered without valid dropping.
	task automatic push_sample(input logic signed [mwsf_pkg::SAMPLE_WIDTH-1:0] value);
		while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
			samples_if.valid <= 1'b0;
			@(posedge clk);
		end
		samples_if.valid <= 1'b1;
		samples_if.sample_value <= value;
		do
			@(posedge clk);
		while (!samples_if.ready);
		items_sent++;
	endtask

	// Quiet the input, wait until every expected result is out, then give the
	// pipeline time to empty (a partial frame leaves no result to wait for).
	task automatic drain();
		samples_if.valid <= 1'b0;
		@(posedge clk);
		wait (open_results == 0);
		repeat (DRAIN_PAD) @(posedge clk);
	endtask

	// Each write drops the enable again before returning, so it never drops and rises in one step.
	task automatic write_reg(input logic [mwsf_pkg::CFG_IDX_W-1:0] idx, input int value);
		wr_index <= idx;
		wr_data <= mwsf_pkg::CFG_DATA_W'(value);
		wr_en <= 1'b1;
		@(posedge clk);
		wr_en <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_side(input int raw);
		write_reg(mwsf_pkg::REG_MATRIX_SIZE, raw);
		side_now = (raw < mwsf_pkg::MIN_SIZE) ? mwsf_pkg::MIN_SIZE :
			(raw > mwsf_pkg::MAX_SIDE) ? mwsf_pkg::MAX_SIDE : raw;
	endtask

	task automatic set_window(input int raw);
		write_reg(mwsf_pkg::REG_WINDOW_SIZE, raw);
	endtask

	function automatic logic signed [mwsf_pkg::SAMPLE_WIDTH-1:0] pick_sample(
		input fill_t kind, input logic signed [mwsf_pkg::SAMPLE_WIDTH-1:0] level);
		case (kind)
			FILL_SMALL: return mwsf_pkg::SAMPLE_WIDTH'(int'($urandom_range(0, 16)) - 8);
			FILL_FLAT:  return level;
			FILL_EDGE:  return $urandom_range(0, 1) ? SAMPLE_MAX : SAMPLE_MIN;
			FILL_LOW:   return SAMPLE_MIN + mwsf_pkg::SAMPLE_WIDTH'($urandom_range(0, 4095));
			default:    return mwsf_pkg::SAMPLE_WIDTH'($urandom);
		endcase
	endfunction

	// one whole matrix at the current size
	task automatic run_frame(input fill_t kind,
		input logic signed [mwsf_pkg::SAMPLE_WIDTH-1:0] level);
		for (int i = 0; i < side_now * side_now; i++)
			push_sample(pick_sample(kind, level));
		frames_sent++;
	endtask

	// mostly small matrices, now and then an out-of-range low write
	function automatic int pick_side();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 5)  return $urandom_range(0, 1);
		if (roll < 70) return $urandom_range(2, 8);
		if (roll < 95) return $urandom_range(9, 12);
		return $urandom_range(13, 20);
	endfunction

	function automatic int pick_window();
		if ($urandom_range(0, 99) < 80)
			return $urandom_range(2, 8);
		return $urandom_range(0, 15);
	endfunction

	// ------------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------------
	initial begin
		int random_start;
		int roll;

		arst_n = 1'b0;
		wr_en = 1'b0;
		wr_index = mwsf_pkg::REG_MATRIX_SIZE;
		wr_data = '0;
		samples_if.valid = 1'b0;
		samples_if.sample_value = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: n below range acts as 2, m below range acts as 2.
		// All-max then all-min frames give the sum extremes; the second frame
		// also checks the restart after a result.
		set_side(1);
		set_window(0);
		run_frame(FILL_FLAT, SAMPLE_MAX);
		run_frame(FILL_FLAT, SAMPLE_MIN);
		drain();

		// m above range acts as 8: no window fits in a 2x2, found must be 0
		set_window(15);
		run_frame(FILL_EDGE, '0);
		drain();

		// part of a frame, then a register write restarts it; the full
		// all-zero frame after it checks that the first window wins a tie
		set_side(3);
		set_window(2);
		repeat (3) push_sample(pick_sample(FILL_FULL, '0));
		drain();
		set_window(2);
		run_frame(FILL_FLAT, '0);
		drain();

		// No idling on either side: n above range acts as 64, a partial frame
		// runs past the first row, then a full 16x16 frame.
		calm = 1'b1;
		set_side(127);
		set_window($urandom_range(0, 15));
		repeat (130) push_sample(pick_sample(FILL_FULL, '0));
		drain();
		set_side(16);
		set_window($urandom_range(0, 15));
		run_frame(FILL_FULL, '0);
		drain();
		calm = 1'b0;

		// Receiver hold-off with tiny frames: the sender keeps offering and the
		// core has to stall the last sample of the following frame.
		set_side(2);
		set_window(2);
		hold_requests++;
		repeat (8) run_frame(fill_t'($urandom_range(0, 4)), mwsf_pkg::SAMPLE_WIDTH'($urandom));
		drain();

		// Random frames under changing sizes
		random_start = items_sent;
		frames_sent = 0;
		while (items_sent - random_start < RANDOM_ITEMS || frames_sent < MIN_FRAMES) begin
			roll = $urandom_range(0, 99);
			if (roll < 10) begin
				// abandoned frame, then a restart by register write
				repeat ($urandom_range(1, side_now * side_now - 1))
					push_sample(pick_sample(FILL_FULL, '0));
				drain();
				set_side(pick_side());
				set_window(pick_window());
			end else if (roll < 60) begin
				drain();
				if ($urandom_range(0, 1))
					set_side(pick_side());
				if ($urandom_range(0, 1))
					set_window(pick_window());
			end
			// otherwise the next frame follows back to back
			run_frame(fill_t'($urandom_range(0, 4)), mwsf_pkg::SAMPLE_WIDTH'($urandom));
		end

		drain();
		if (mismatch_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
